// ===== src/swa_pkg.sv =====
// Shared constants, slice record type and ring index helper for the sliding window average.
package swa_pkg;

    localparam int SLICES  = 64;
    localparam int IDX_W   = $clog2(SLICES);
    localparam int OCC_W   = $clog2(SLICES + 1);
    localparam int RING_W  = OCC_W + 1;

    localparam int TIME_W  = 32;
    localparam int SPEED_W = 16;
    localparam int WIN_W   = 31;
    localparam int SSUM_W  = 32;
    localparam int SCNT_W  = 16;
    localparam int SUM_W   = 38;
    localparam int CNT_W   = 22;
    localparam int AVG_W   = 16;

    localparam logic [SCNT_W-1:0] SLICE_COUNT_MAX = '1;
    localparam logic [WIN_W-1:0]  WINDOW_RESET    = WIN_W'(300000);

    localparam logic KIND_VEHICLE = 1'b0;
    localparam logic KIND_TICK    = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0] stamp;
        logic [SSUM_W-1:0] sum;
        logic [SCNT_W-1:0] count;
    } slice_t;

    // Position base + off in the ring; both operands are below 2*SLICES in sum.
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                  input logic [OCC_W-1:0] off);
        logic [RING_W-1:0] s;
        s = RING_W'(base) + RING_W'(off);
        if (s >= RING_W'(SLICES))
        begin
            s = s - RING_W'(SLICES);
        end
        return s[IDX_W-1:0];
    endfunction

endpackage

// ===== src/swa_avg_div.sv =====
// Radix-2 restoring divider for the window average, one quotient bit per cycle.
module swa_avg_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [swa_pkg::SUM_W-1:0] dividend,
    input  logic [swa_pkg::CNT_W-1:0] divisor,
    output logic                      done,
    output logic [swa_pkg::AVG_W-1:0] quotient
);
    import swa_pkg::*;

    localparam int STEP_W = $clog2(AVG_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [AVG_W-1:0]  q_reg;
    logic [CNT_W-1:0]  div_reg;
    logic [CNT_W:0]    trial;
    logic              q_bit;
    logic [CNT_W:0]    diff;

    // The average never exceeds the largest speed, so the upper dividend bits
    // are already below the divisor and only AVG_W steps are needed.
    assign trial = {rem_reg, q_reg[AVG_W-1]};
    assign q_bit = (trial >= {1'b0, div_reg});
    assign diff  = trial - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (step_reg == STEP_W'(AVG_W - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(AVG_W - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[SUM_W-1:AVG_W];
            q_reg   <= dividend[AVG_W-1:0];
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= q_bit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            q_reg   <= {q_reg[AVG_W-2:0], q_bit};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== src/sliding_window_average_speed.sv =====
// Sliding window average speed: a vehicle transfer yields one result after it reads the newest
// slice (with an extra eviction step when a full ring evicts its oldest slice); a tick reads the
// slices from the oldest on, paced by the slice memory read for each slice visited and the
// 16-step average divider. The next transfer is taken in the cycle after the result is loaded.
// Input is stalled while an item is in work; a finished result waits in the output register
// while the next item is taken.
// The slice memory needs no clearing after reset; window_ms may be written when idle.
module sliding_window_average_speed (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        window_ms_we,
    input  logic [swa_pkg::WIN_W-1:0]   window_ms,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        kind,
    input  logic [swa_pkg::TIME_W-1:0]  time_ms,
    input  logic [swa_pkg::SPEED_W-1:0] speed,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [swa_pkg::AVG_W-1:0]   avg_speed,
    output logic [swa_pkg::CNT_W-1:0]   vehicle_count,
    output logic [6:0]                  slices_used,
    output logic                        evicted_early
);
    import swa_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_NEW_CHK  = 7'b0000010,
        S_EVICT    = 7'b0000100,
        S_TICK     = 7'b0001000,
        S_DIV_GO   = 7'b0010000,
        S_DIV_WAIT = 7'b0100000,
        S_DONE     = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    logic [WIN_W-1:0]   window_reg;
    logic [IDX_W-1:0]   oldest_reg, oldest_next;
    logic [OCC_W-1:0]   occ_reg, occ_next;
    logic [SUM_W-1:0]   tsum_reg, tsum_next;
    logic [CNT_W-1:0]   tcnt_reg, tcnt_next;
    logic               kind_reg, kind_next;
    logic [TIME_W-1:0]  time_reg, time_next;
    logic [SPEED_W-1:0] speed_reg, speed_next;
    logic               empty_reg, empty_next;
    logic               evict_reg, evict_next;

    logic               out_valid_reg;
    logic [AVG_W-1:0]   avg_reg;
    logic [CNT_W-1:0]   cnt_out_reg;
    logic [OCC_W-1:0]   occ_out_reg;
    logic               evict_out_reg;
    logic               load_out;

    slice_t             mem [SLICES];
    slice_t             rd_data_reg;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    slice_t             wr_data;

    logic [IDX_W-1:0]   newest_idx;
    logic [IDX_W-1:0]   next_idx;
    logic [IDX_W-1:0]   oldest_plus1;
    logic [TIME_W-1:0]  age;
    logic               expired;
    logic               div_start;
    logic               div_done;
    logic [AVG_W-1:0]   div_q;

    assign newest_idx   = ring_add(oldest_reg, occ_reg - 1'b1);
    assign next_idx     = ring_add(oldest_reg, occ_reg);
    assign oldest_plus1 = ring_add(oldest_reg, OCC_W'(1));

    // A slice stamped later than the tick time counts as age zero.
    assign age     = (time_reg >= rd_data_reg.stamp) ? (time_reg - rd_data_reg.stamp) : '0;
    assign expired = (age >= {1'b0, window_reg});

    assign div_start = (state_reg == S_DIV_GO);

    swa_avg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (tsum_reg),
        .divisor  (tcnt_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        oldest_next = oldest_reg;
        occ_next    = occ_reg;
        tsum_next   = tsum_reg;
        tcnt_next   = tcnt_reg;
        kind_next   = kind_reg;
        time_next   = time_reg;
        speed_next  = speed_reg;
        empty_next  = empty_reg;
        evict_next  = evict_reg;
        rd_en       = 1'b0;
        rd_addr     = oldest_reg;
        wr_en       = 1'b0;
        wr_addr     = next_idx;
        wr_data     = '{stamp: time_reg, sum: SSUM_W'(speed_reg), count: SCNT_W'(1)};
        load_out    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next  = kind;
                    time_next  = time_ms;
                    speed_next = speed;
                    empty_next = (occ_reg == '0);
                    evict_next = 1'b0;
                    if (kind == KIND_VEHICLE)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = newest_idx;
                        state_next = S_NEW_CHK;
                    end
                    else if ((window_reg == '0) || (occ_reg == '0))
                    begin
                        state_next = S_DIV_GO;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = oldest_reg;
                        state_next = S_TICK;
                    end
                end
            end

            S_NEW_CHK:
            begin
                if (!empty_reg && (rd_data_reg.stamp == time_reg))
                begin
                    // Same time as the newest slice: add unless its count is saturated.
                    if (rd_data_reg.count != SLICE_COUNT_MAX)
                    begin
                        wr_en     = 1'b1;
                        wr_addr   = newest_idx;
                        wr_data   = '{stamp: rd_data_reg.stamp,
                                      sum:   rd_data_reg.sum + SSUM_W'(speed_reg),
                                      count: rd_data_reg.count + 1'b1};
                        tsum_next = tsum_reg + SUM_W'(speed_reg);
                        tcnt_next = tcnt_reg + 1'b1;
                    end
                    state_next = S_DIV_GO;
                end
                else if (occ_reg == OCC_W'(SLICES))
                begin
                    rd_en      = 1'b1;
                    rd_addr    = oldest_reg;
                    state_next = S_EVICT;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = next_idx;
                    occ_next   = occ_reg + 1'b1;
                    tsum_next  = tsum_reg + SUM_W'(speed_reg);
                    tcnt_next  = tcnt_reg + 1'b1;
                    state_next = S_DIV_GO;
                end
            end

            S_EVICT:
            begin
                // The new slice takes the place of the evicted oldest one.
                wr_en       = 1'b1;
                wr_addr     = oldest_reg;
                oldest_next = oldest_plus1;
                tsum_next   = tsum_reg - SUM_W'(rd_data_reg.sum) + SUM_W'(speed_reg);
                tcnt_next   = tcnt_reg - CNT_W'(rd_data_reg.count) + 1'b1;
                evict_next  = 1'b1;
                state_next  = S_DIV_GO;
            end

            S_TICK:
            begin
                if (expired)
                begin
                    tsum_next   = tsum_reg - SUM_W'(rd_data_reg.sum);
                    tcnt_next   = tcnt_reg - CNT_W'(rd_data_reg.count);
                    occ_next    = occ_reg - 1'b1;
                    oldest_next = oldest_plus1;
                    if (occ_reg != OCC_W'(1))
                    begin
                        rd_en   = 1'b1;
                        rd_addr = oldest_plus1;
                    end
                    else
                    begin
                        state_next = S_DIV_GO;
                    end
                end
                else
                begin
                    state_next = S_DIV_GO;
                end
            end

            S_DIV_GO:
            begin
                state_next = S_DIV_WAIT;
            end

            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            window_reg    <= WINDOW_RESET;
            oldest_reg    <= '0;
            occ_reg       <= '0;
            tsum_reg      <= '0;
            tcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            oldest_reg <= oldest_next;
            occ_reg    <= occ_next;
            tsum_reg   <= tsum_next;
            tcnt_reg   <= tcnt_next;
            if (window_ms_we)
            begin
                window_reg <= window_ms;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        time_reg  <= time_next;
        speed_reg <= speed_next;
        empty_reg <= empty_next;
        evict_reg <= evict_next;
        if (load_out)
        begin
            avg_reg       <= (tcnt_reg == '0) ? '0 : div_q;
            cnt_out_reg   <= tcnt_reg;
            occ_out_reg   <= occ_reg;
            evict_out_reg <= evict_reg && (kind_reg == KIND_VEHICLE);
        end
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign avg_speed     = avg_reg;
    assign vehicle_count = cnt_out_reg;
    assign slices_used   = 7'(occ_out_reg);
    assign evicted_early = evict_out_reg;

    // An accepted item keeps the input stalled until its result is formed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while an item was in work");

    // An early eviction only happens with every slice in use.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && evicted_early) |-> (slices_used == 7'(SLICES)))
        else $error("eviction reported with a ring that is not full");

    // No slices means no vehicles, and no vehicles means a zero average.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (slices_used == '0)) |-> (vehicle_count == '0))
        else $error("vehicles counted with an empty ring");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (vehicle_count == '0)) |-> (avg_speed == '0))
        else $error("nonzero average with no vehicles");

    // The divider finishes only while the controller waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV_WAIT))
        else $error("divider result outside the wait state");

endmodule
